[rtl/core/uart_bootloader_host_sequencer_assert.svh]
// Assertion macros for the UART bootloader host sequencer.
// Included by the modules that carry concurrent assertions; no other dependencies.
`ifndef UART_BOOTLOADER_HOST_SEQUENCER_ASSERT_SVH
`define UART_BOOTLOADER_HOST_SEQUENCER_ASSERT_SVH
`ifndef SYNTHESIS
// A property that must hold at every clock edge outside reset.
`define UBHS_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// A condition in one cycle that forces another in the following cycle.
`define UBHS_ASSERT_NEXT(lbl, clk, rstn, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) pre |=> post) else $error(msg);
`else
`define UBHS_ASSERT_CLK(lbl, clk, rstn, prop, msg)
`define UBHS_ASSERT_NEXT(lbl, clk, rstn, pre, post, msg)
`endif
`endif

[rtl/core/ubhs_pkg.sv]
// Shared types, codes and constants of the UART bootloader host sequencer.
// No dependencies; used by ubhs_core and the top level.
package ubhs_pkg;

    localparam int IDX_W               = 9;
    localparam int BLOCK_BYTES_DEFAULT = 256;
    localparam int S_TDATA_W           = 24;
    localparam int S_TUSER_W           = 3;
    localparam int M_TDATA_W           = 72;
    localparam logic [31:0] FLASH_BASE_RESET = 32'h0800_0000;

    localparam logic [7:0] ACK_BYTE   = 8'h79;
    localparam logic [7:0] NACK_BYTE  = 8'h1F;
    localparam logic [7:0] ID_PREFIX  = 8'h01;
    localparam logic [7:0] FILL_BYTE  = 8'hFF;
    localparam logic [7:0] ZERO_BYTE  = 8'h00;

    // Event kinds of an input item.
    localparam logic [2:0] CMD_START    = 3'd0;
    localparam logic [2:0] CMD_RX       = 3'd1;
    localparam logic [2:0] CMD_TIMEOUT  = 3'd2;
    localparam logic [2:0] CMD_TX_READY = 3'd3;
    localparam logic [2:0] CMD_LOAD     = 3'd4;

    // Operations.
    localparam logic [2:0] OP_CONNECT   = 3'd0;
    localparam logic [2:0] OP_VERSION   = 3'd1;
    localparam logic [2:0] OP_CHIP_ID   = 3'd2;
    localparam logic [2:0] OP_UNPROTECT = 3'd3;
    localparam logic [2:0] OP_ERASE     = 3'd4;
    localparam logic [2:0] OP_EXT_ERASE = 3'd5;
    localparam logic [2:0] OP_WRITE     = 3'd6;
    localparam logic [2:0] OP_GO        = 3'd7;

    // Completion status codes.
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_COMM     = 2'd1;
    localparam logic [1:0] ST_CONN     = 2'd2;
    localparam logic [1:0] ST_NOT_CONN = 2'd3;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_TX_CMD,
        PH_W_CONN,
        PH_W_ACK1,
        PH_W_TOTAL,
        PH_W_VBYTES,
        PH_W_ONE,
        PH_W_VH,
        PH_W_VL,
        PH_W_ACKEND,
        PH_TX_ERASE,
        PH_TX_EXT,
        PH_TX_ADDR,
        PH_W_ACK_ADDR,
        PH_TX_DATA
    } phase_t;

    typedef struct packed {
        logic [2:0] cmd;
        logic [2:0] operation;
        logic [7:0] rx_value;
        logic [7:0] payload_byte;
        logic       restart_address;
    } item_t;

    // Last member sits in the lowest bits, matching the m_tdata layout.
    typedef struct packed {
        logic [31:0] next_address;
        logic [15:0] device_id;
        logic [3:0]  version_minor;
        logic [3:0]  version_major;
        logic        busy_res;
        logic [1:0]  status;
        logic        op_done;
        logic [7:0]  tx_value;
        logic        tx_valid;
    } result_t;

    typedef struct packed {
        logic   valid;
        logic   last;
        logic [7:0] data;
        phase_t after;
    } send_t;

    function automatic logic [7:0] op_code(input logic [2:0] op);
        logic [7:0] code;
        case (op)
            OP_CONNECT:   code = 8'h7F;
            OP_VERSION:   code = 8'h00;
            OP_CHIP_ID:   code = 8'h02;
            OP_UNPROTECT: code = 8'h73;
            OP_ERASE:     code = 8'h43;
            OP_EXT_ERASE: code = 8'h44;
            OP_WRITE:     code = 8'h31;
            OP_GO:        code = 8'h21;
            default:      code = 8'h00;
        endcase
        return code;
    endfunction

endpackage

[rtl/core/uart_bootloader_host_sequencer.sv]
// An accepted item waits in the input register until the core moves its result into m_tdata.
// Throughput: one item per cycle while m_tready is high; a result held back by m_tready keeps
// the item behind it in the input register, and s_tready stays low until the result is taken.
// The event logic between the input register and the result register is one short pass.
// Reset (aresetn low, synchronous) empties both registers, returns to idle and disconnected,
// and reloads the flash base; the block buffer is not cleared, so no sweep follows reset.
//
// Top level of the UART bootloader host sequencer: stream channels, config port and
// assertions. Depends on ubhs_pkg, ubhs_core and the assertion macro header.
`include "uart_bootloader_host_sequencer_assert.svh"

module uart_bootloader_host_sequencer
    import ubhs_pkg::*;
#(
    parameter int BLOCK_BYTES = BLOCK_BYTES_DEFAULT
) (
    input  logic                 aclk,
    input  logic                 aresetn,

    // Configuration: the flash base address register.
    input  logic                 cfg_we,
    input  logic [31:0]          cfg_wdata,

    // Input items.
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // From bit 0: operation[2:0], rx_value[10:3], payload_byte[18:11],
    // restart_address[19], zero fill [23:20].
    input  logic [S_TDATA_W-1:0] s_tdata,
    // From bit 0: cmd[2:0].
    input  logic [S_TUSER_W-1:0] s_tuser,

    // Result items.
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // From bit 0: tx_valid[0], tx_value[8:1], op_done[9], status[11:10],
    // busy_res[12], version_major[16:13], version_minor[20:17],
    // device_id[36:21], next_address[68:37], zero fill [71:69].
    output logic [M_TDATA_W-1:0] m_tdata
);

    localparam int RES_W = $bits(result_t);

    // The input register holds one accepted item until the core consumes it.
    logic    in_valid_reg, in_valid_next;
    item_t   in_item_reg;
    // The result register holds the last produced result until it is taken.
    logic    out_valid_reg, out_valid_next;
    result_t res_reg;

    logic    advance;
    logic    s_fire;
    item_t   s_item;
    result_t res;

    // The core consumes the held item whenever the result register is free or
    // is being emptied in this same cycle.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_fire   = s_tvalid && s_tready;

    always_comb begin
        s_item.cmd             = s_tuser[2:0];
        s_item.operation       = s_tdata[2:0];
        s_item.rx_value        = s_tdata[10:3];
        s_item.payload_byte    = s_tdata[18:11];
        s_item.restart_address = s_tdata[19];
    end

    assign in_valid_next  = s_fire || (in_valid_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && !m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_item_reg <= s_item;
        end
        if (advance) begin
            res_reg <= res;
        end
    end

    ubhs_core #(
        .BLOCK_BYTES (BLOCK_BYTES)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (advance),
        .item      (in_item_reg),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .result    (res)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(M_TDATA_W - RES_W)'(0), res_reg};

    // A transmitted byte always leaves an operation in progress behind it.
    `UBHS_ASSERT_CLK(a_tx_while_busy, aclk, aresetn, out_valid_reg && res_reg.tx_valid |-> res_reg.busy_res, "tx byte reported with the sequencer idle")
    // An operation that reports completion must leave the sequencer idle.
    `UBHS_ASSERT_CLK(a_done_idle, aclk, aresetn, out_valid_reg && res_reg.op_done |-> !res_reg.busy_res, "op_done reported while still busy")
    // Every item consumed by the core shows up as a held result.
    `UBHS_ASSERT_NEXT(a_advance_result, aclk, aresetn, advance, out_valid_reg, "consumed item produced no result")
    // A result appears only after the core consumed an item.
    `UBHS_ASSERT_CLK(a_result_source, aclk, aresetn, $rose(out_valid_reg) |-> $past(advance), "result appeared without a consumed item")

endmodule

[rtl/core/ubhs_ram.sv]
// Generic single-port-write, single-port-read RAM with a registered read.
// Standalone; used by ubhs_core for the block data buffer.
module ubhs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                                   aclk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/core/ubhs_core.sv]
// Protocol state and single-pass event logic of the bootloader host sequencer.
// Depends on ubhs_pkg and ubhs_ram (block data buffer).
module ubhs_core
    import ubhs_pkg::*;
#(
    parameter int BLOCK_BYTES = BLOCK_BYTES_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        advance,
    input  item_t       item,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,
    output result_t     result
);

    localparam int CNT_W  = $clog2(BLOCK_BYTES + 1);
    localparam int ADDR_W = (BLOCK_BYTES > 1) ? $clog2(BLOCK_BYTES) : 1;

    phase_t             phase_reg, phase_next;
    logic [2:0]         active_op_reg, active_op_next;
    logic               connected_reg, connected_next;
    logic [31:0]        write_address_reg, write_address_next;
    logic [IDX_W-1:0]   byte_index_reg, byte_index_next;
    logic [7:0]         running_xor_reg, running_xor_next;
    logic [CNT_W-1:0]   block_count_reg, block_count_next;
    logic [IDX_W-1:0]   rx_remaining_reg, rx_remaining_next;
    logic [7:0]         version_value_reg, version_value_next;
    logic [15:0]        id_value_reg, id_value_next;
    logic [1:0]         status_reg, status_next;
    logic [31:0]        flash_base_reg;

    // Send selection and the byte it produces.
    logic               sel_open;
    phase_t             sel_phase;
    logic               sel_txr;
    phase_t             send_phase;
    logic [IDX_W-1:0]   send_idx;
    logic [7:0]         send_xor;
    logic [2:0]         send_op;
    send_t              snd;

    logic [IDX_W-1:0]   cnt_ext;
    logic [IDX_W-1:0]   cnt_m1;
    logic [IDX_W-1:0]   send_len;
    logic [IDX_W-1:0]   send_idx_inc;
    logic [31:0]        addr_sel;
    logic [7:0]         addr_byte;

    logic               rx_ack;
    logic [7:0]         vbytes_xor;
    logic [IDX_W-1:0]   rem_dec;
    logic               fin;
    logic [1:0]         fin_status;
    logic               conn_tx;
    logic               load_we;

    logic [IDX_W-1:0]   rd_index;
    logic [ADDR_W-1:0]  ram_raddr;
    logic [7:0]         ram_rdata;

    assign rx_ack  = (item.rx_value == ACK_BYTE);
    assign cnt_ext = IDX_W'(block_count_reg);
    assign cnt_m1  = cnt_ext - IDX_W'(1);

    // Which transmit group, if any, this item feeds: a fresh group opened by a
    // start or an ACK, or the next byte of the current group on a tx-ready.
    always_comb begin
        sel_open  = 1'b0;
        sel_phase = PH_IDLE;
        sel_txr   = 1'b0;
        case (item.cmd)
            CMD_START: begin
                if (phase_reg == PH_IDLE && item.operation != OP_CONNECT && connected_reg
                    && !(item.operation == OP_WRITE && block_count_reg == '0)) begin
                    sel_open  = 1'b1;
                    sel_phase = PH_TX_CMD;
                end
            end
            CMD_RX: begin
                if (phase_reg == PH_W_ACK1 && rx_ack) begin
                    if (active_op_reg == OP_ERASE) begin
                        sel_open  = 1'b1;
                        sel_phase = PH_TX_ERASE;
                    end else if (active_op_reg == OP_EXT_ERASE) begin
                        sel_open  = 1'b1;
                        sel_phase = PH_TX_EXT;
                    end else if (!(active_op_reg inside {OP_VERSION, OP_CHIP_ID,
                                                          OP_UNPROTECT})) begin
                        sel_open  = 1'b1;
                        sel_phase = PH_TX_ADDR;
                    end
                end else if (phase_reg == PH_W_ACK_ADDR && rx_ack
                             && active_op_reg == OP_WRITE) begin
                    sel_open  = 1'b1;
                    sel_phase = PH_TX_DATA;
                end
            end
            CMD_TX_READY: begin
                sel_txr = 1'b1;
            end
            default: begin
                sel_txr = 1'b0;
            end
        endcase
    end

    assign send_phase   = sel_open ? sel_phase : phase_reg;
    assign send_idx     = sel_open ? '0 : byte_index_reg;
    assign send_xor     = sel_open ? 8'h00 : running_xor_reg;
    assign send_op      = (item.cmd == CMD_START) ? item.operation : active_op_reg;
    assign send_idx_inc = send_idx + IDX_W'(1);
    assign addr_sel     = (send_op == OP_WRITE) ? write_address_reg : flash_base_reg;

    always_comb begin
        case (send_idx[1:0])
            2'd0:    addr_byte = addr_sel[31:24];
            2'd1:    addr_byte = addr_sel[23:16];
            2'd2:    addr_byte = addr_sel[15:8];
            default: addr_byte = addr_sel[7:0];
        endcase
    end

    // Byte generator for the transmit groups.
    always_comb begin
        snd.valid = sel_open | sel_txr;
        snd.data  = 8'h00;
        snd.after = PH_W_ACKEND;
        send_len  = IDX_W'(2);
        case (send_phase)
            PH_TX_CMD: begin
                snd.data  = (send_idx == '0) ? op_code(send_op) : ~op_code(send_op);
                snd.after = PH_W_ACK1;
            end
            PH_TX_ERASE: begin
                snd.data = (send_idx == '0) ? FILL_BYTE : ZERO_BYTE;
            end
            PH_TX_EXT: begin
                snd.data = (send_idx < IDX_W'(2)) ? FILL_BYTE : ZERO_BYTE;
                send_len = IDX_W'(3);
            end
            PH_TX_ADDR: begin
                snd.data  = (send_idx < IDX_W'(4)) ? addr_byte : send_xor;
                send_len  = IDX_W'(5);
                snd.after = PH_W_ACK_ADDR;
            end
            PH_TX_DATA: begin
                if (send_idx == '0) begin
                    snd.data = cnt_m1[7:0];
                end else if (send_idx <= cnt_ext) begin
                    snd.data = ram_rdata;
                end else begin
                    snd.data = send_xor;
                end
                send_len = cnt_ext + IDX_W'(2);
            end
            default: begin
                snd.valid = 1'b0;
            end
        endcase
        snd.last = (send_idx_inc >= send_len);
    end

    assign vbytes_xor = (byte_index_reg == '0) ? item.rx_value : running_xor_reg;
    assign rem_dec    = (rx_remaining_reg != '0) ? rx_remaining_reg - IDX_W'(1)
                                                 : rx_remaining_reg;

    // Next-state logic.
    always_comb begin
        phase_next         = phase_reg;
        active_op_next     = active_op_reg;
        connected_next     = connected_reg;
        write_address_next = write_address_reg;
        byte_index_next    = byte_index_reg;
        running_xor_next   = running_xor_reg;
        block_count_next   = block_count_reg;
        rx_remaining_next  = rx_remaining_reg;
        version_value_next = version_value_reg;
        id_value_next      = id_value_reg;
        status_next        = status_reg;
        fin                = 1'b0;
        fin_status         = ST_OK;
        conn_tx            = 1'b0;
        load_we            = 1'b0;

        if (snd.valid) begin
            running_xor_next = send_xor ^ snd.data;
            byte_index_next  = send_idx_inc;
            phase_next       = snd.last ? snd.after : send_phase;
        end

        case (item.cmd)
            CMD_START: begin
                if (phase_reg == PH_IDLE) begin
                    active_op_next    = item.operation;
                    rx_remaining_next = '0;
                    if (item.operation == OP_CONNECT) begin
                        conn_tx    = 1'b1;
                        phase_next = PH_W_CONN;
                    end else if (!connected_reg) begin
                        fin        = 1'b1;
                        fin_status = ST_NOT_CONN;
                    end else if (item.operation == OP_WRITE) begin
                        if (item.restart_address) begin
                            write_address_next = flash_base_reg;
                        end
                        if (block_count_reg == '0) begin
                            fin        = 1'b1;
                            fin_status = ST_OK;
                        end
                    end
                end
            end
            CMD_RX: begin
                case (phase_reg)
                    PH_W_CONN: begin
                        connected_next = rx_ack || (item.rx_value == NACK_BYTE);
                        fin            = 1'b1;
                        fin_status     = connected_next ? ST_OK : ST_CONN;
                    end
                    PH_W_ACK1: begin
                        if (!rx_ack) begin
                            fin        = 1'b1;
                            fin_status = ST_COMM;
                        end else if (active_op_reg == OP_VERSION) begin
                            phase_next = PH_W_TOTAL;
                        end else if (active_op_reg == OP_CHIP_ID) begin
                            phase_next = PH_W_ONE;
                        end else if (active_op_reg == OP_UNPROTECT) begin
                            phase_next = PH_W_ACKEND;
                        end
                    end
                    PH_W_TOTAL: begin
                        rx_remaining_next = IDX_W'(item.rx_value) + IDX_W'(1);
                        byte_index_next   = '0;
                        phase_next        = PH_W_VBYTES;
                    end
                    PH_W_VBYTES: begin
                        running_xor_next  = vbytes_xor;
                        byte_index_next   = byte_index_reg + IDX_W'(1);
                        rx_remaining_next = rem_dec;
                        if (rem_dec == '0) begin
                            version_value_next = vbytes_xor;
                            phase_next         = PH_W_ACKEND;
                        end
                    end
                    PH_W_ONE: begin
                        if (item.rx_value != ID_PREFIX) begin
                            fin        = 1'b1;
                            fin_status = ST_COMM;
                        end else begin
                            phase_next = PH_W_VH;
                        end
                    end
                    PH_W_VH: begin
                        running_xor_next = item.rx_value;
                        phase_next       = PH_W_VL;
                    end
                    PH_W_VL: begin
                        rx_remaining_next = IDX_W'(item.rx_value);
                        phase_next        = PH_W_ACKEND;
                    end
                    PH_W_ACK_ADDR: begin
                        if (!rx_ack) begin
                            fin        = 1'b1;
                            fin_status = ST_COMM;
                        end else if (active_op_reg != OP_WRITE) begin
                            fin        = 1'b1;
                            fin_status = ST_OK;
                        end
                    end
                    PH_W_ACKEND: begin
                        fin = 1'b1;
                        if (!rx_ack) begin
                            fin_status = ST_COMM;
                        end else begin
                            fin_status = ST_OK;
                            if (active_op_reg == OP_CHIP_ID) begin
                                id_value_next = {running_xor_reg, rx_remaining_reg[7:0]};
                            end
                            if (active_op_reg == OP_WRITE) begin
                                write_address_next = write_address_reg
                                                     + 32'(block_count_reg);
                                block_count_next   = '0;
                            end
                        end
                    end
                    default: begin
                        fin = 1'b0;
                    end
                endcase
            end
            CMD_TIMEOUT: begin
                if (phase_reg == PH_W_CONN) begin
                    connected_next = 1'b0;
                    fin            = 1'b1;
                    fin_status     = ST_CONN;
                end else if (phase_reg == PH_W_ACKEND && active_op_reg == OP_EXT_ERASE) begin
                    fin = 1'b0;
                end else if (phase_reg inside {PH_W_ACK1, PH_W_TOTAL, PH_W_VBYTES, PH_W_ONE,
                                               PH_W_VH, PH_W_VL, PH_W_ACK_ADDR,
                                               PH_W_ACKEND}) begin
                    fin        = 1'b1;
                    fin_status = ST_COMM;
                end
            end
            CMD_LOAD: begin
                if (phase_reg == PH_IDLE && block_count_reg < CNT_W'(BLOCK_BYTES)) begin
                    load_we          = 1'b1;
                    block_count_next = block_count_reg + CNT_W'(1);
                end
            end
            default: begin
                fin = 1'b0;
            end
        endcase

        if (fin) begin
            phase_next  = PH_IDLE;
            status_next = fin_status;
        end
    end

    // Result fields, taken from the state as it stands after this item.
    always_comb begin
        result.tx_valid      = snd.valid | conn_tx;
        result.tx_value      = conn_tx ? op_code(OP_CONNECT)
                                       : (snd.valid ? snd.data : 8'h00);
        result.op_done       = fin;
        result.status        = status_next;
        result.busy_res      = (phase_next != PH_IDLE);
        result.version_major = version_value_next[7:4];
        result.version_minor = version_value_next[3:0];
        result.device_id     = id_value_next;
        result.next_address  = write_address_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg         <= PH_IDLE;
            active_op_reg     <= OP_CONNECT;
            connected_reg     <= 1'b0;
            write_address_reg <= FLASH_BASE_RESET;
            byte_index_reg    <= '0;
            running_xor_reg   <= 8'h00;
            block_count_reg   <= '0;
            rx_remaining_reg  <= '0;
            version_value_reg <= 8'h00;
            id_value_reg      <= 16'h0000;
            status_reg        <= ST_OK;
            flash_base_reg    <= FLASH_BASE_RESET;
        end else begin
            if (advance) begin
                phase_reg         <= phase_next;
                active_op_reg     <= active_op_next;
                connected_reg     <= connected_next;
                write_address_reg <= write_address_next;
                byte_index_reg    <= byte_index_next;
                running_xor_reg   <= running_xor_next;
                block_count_reg   <= block_count_next;
                rx_remaining_reg  <= rx_remaining_next;
                version_value_reg <= version_value_next;
                id_value_reg      <= id_value_next;
                status_reg        <= status_next;
            end
            if (cfg_we) begin
                flash_base_reg <= cfg_wdata;
            end
        end
    end

    // The buffer is read one item ahead: the address is the entry that the
    // next data byte of the group will need, so the registered read is ready.
    assign rd_index  = (advance ? byte_index_next : byte_index_reg) - IDX_W'(1);
    assign ram_raddr = rd_index[ADDR_W-1:0];

    ubhs_ram #(
        .WIDTH (8),
        .DEPTH (BLOCK_BYTES)
    ) u_block_ram (
        .aclk  (aclk),
        .we    (advance & load_we),
        .waddr (block_count_reg[ADDR_W-1:0]),
        .wdata (item.payload_byte),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

endmodule

[tb/tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for uart_bootloader_host_sequencer: directed cases, a full block
// and random bootloader exchanges. Depends on ubhs_pkg and the RTL top.
module tb;
    import ubhs_pkg::*;

    // Command byte of each operation, operation 0 in the lowest byte.
    localparam logic [63:0] CMD_CODES  = 64'h21_31_44_43_73_02_00_7F;
    // An event kind that the block has no use for.
    localparam logic [2:0]  CMD_UNUSED = 3'd7;
    localparam int          MAX_PRINTS = 40;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [31:0]          cfg_wdata = 32'h0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    logic [S_TUSER_W-1:0] s_tuser   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    uart_bootloader_host_sequencer u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // 20 ns period.
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Shadow of the sequencer. Every accepted input item produces exactly one result item,
    // so the queue below holds one entry per item still in flight.
    logic [31:0] seq_base;
    phase_t      seq_phase;
    logic [2:0]  seq_op;
    logic        seq_linked;
    logic [31:0] seq_addr;
    logic [8:0]  seq_index;
    logic [7:0]  seq_xor;
    logic [7:0]  seq_buf [0:255];
    logic [8:0]  seq_count;
    logic [8:0]  seq_remaining;
    logic [7:0]  seq_version;
    logic [15:0] seq_id;
    logic [1:0]  seq_status;
    logic        tx_flag;
    logic [7:0]  tx_byte;
    logic        done_flag;

    result_t     due_outputs [$];
    result_t     seen;

    int unsigned gap_pct         = 0;
    int unsigned stall_pct       = 0;
    int unsigned fill_goal       = 3;
    int unsigned error_count     = 0;
    int unsigned results_checked = 0;
    int unsigned items_sent      = 0;
    int unsigned ops_ended       = 0;
    int unsigned base_settings   = 0;

    function automatic void seq_reset();
        seq_base      = FLASH_BASE_RESET;
        seq_phase     = PH_IDLE;
        seq_op        = OP_CONNECT;
        seq_linked    = 1'b0;
        seq_addr      = FLASH_BASE_RESET;
        seq_index     = '0;
        seq_xor       = '0;
        seq_count     = '0;
        seq_remaining = '0;
        seq_version   = '0;
        seq_id        = '0;
        seq_status    = ST_OK;
    endfunction

    function automatic void end_op(input logic [1:0] st);
        seq_status = st;
        seq_phase  = PH_IDLE;
        done_flag  = 1'b1;
    endfunction

    // Puts the next byte of the current transmit group on the line, if a group is open.
    function automatic void emit_next();
        logic [7:0]  b;
        logic [31:0] addr;
        int unsigned i;
        int unsigned len;
        phase_t      nxt;
        i    = seq_index;
        len  = 2;
        nxt  = PH_W_ACKEND;
        b    = ZERO_BYTE;
        addr = (seq_op == OP_WRITE) ? seq_addr : seq_base;
        case (seq_phase)
            PH_TX_CMD: begin
                b = CMD_CODES[int'(seq_op) * 8 +: 8];
                if (i != 0) b = ~b;
                nxt = PH_W_ACK1;
            end
            PH_TX_ERASE: b = (i == 0) ? FILL_BYTE : ZERO_BYTE;
            PH_TX_EXT: begin
                b   = (i < 2) ? FILL_BYTE : ZERO_BYTE;
                len = 3;
            end
            PH_TX_ADDR: begin
                if (i < 4) b = addr[(3 - i) * 8 +: 8];
                else b = seq_xor;
                len = 5;
                nxt = PH_W_ACK_ADDR;
            end
            PH_TX_DATA: begin
                if (i == 0) b = seq_count[7:0] - 8'd1;
                else if (i <= seq_count) b = seq_buf[(i - 1) % 256];
                else b = seq_xor;
                len = seq_count + 2;
            end
            default: return;
        endcase
        seq_xor   = seq_xor ^ b;
        tx_flag   = 1'b1;
        tx_byte   = b;
        seq_index = seq_index + 9'd1;
        if (seq_index >= len) seq_phase = nxt;
    endfunction

    function automatic void open_group(input phase_t p);
        seq_phase = p;
        seq_index = '0;
        seq_xor   = '0;
        emit_next();
    endfunction

    function automatic void take_rx(input logic [7:0] b);
        logic ack;
        ack = (b == ACK_BYTE);
        case (seq_phase)
            PH_W_CONN: begin
                seq_linked = (b == ACK_BYTE) || (b == NACK_BYTE);
                end_op(seq_linked ? ST_OK : ST_CONN);
            end
            PH_W_ACK1: begin
                if (!ack) end_op(ST_COMM);
                else begin
                    case (seq_op)
                        OP_VERSION:   seq_phase = PH_W_TOTAL;
                        OP_CHIP_ID:   seq_phase = PH_W_ONE;
                        OP_UNPROTECT: seq_phase = PH_W_ACKEND;
                        OP_ERASE:     open_group(PH_TX_ERASE);
                        OP_EXT_ERASE: open_group(PH_TX_EXT);
                        default:      open_group(PH_TX_ADDR);
                    endcase
                end
            end
            PH_W_TOTAL: begin
                seq_remaining = {1'b0, b} + 9'd1;
                seq_index     = '0;
                seq_phase     = PH_W_VBYTES;
            end
            PH_W_VBYTES: begin
                // Only the first byte of the list is the version; the rest are command codes.
                if (seq_index == 0) seq_xor = b;
                seq_index = seq_index + 9'd1;
                if (seq_remaining != 0) seq_remaining = seq_remaining - 9'd1;
                if (seq_remaining == 0) begin
                    seq_version = seq_xor;
                    seq_phase   = PH_W_ACKEND;
                end
            end
            PH_W_ONE: begin
                if (b != ID_PREFIX) end_op(ST_COMM);
                else seq_phase = PH_W_VH;
            end
            PH_W_VH: begin
                seq_xor   = b;
                seq_phase = PH_W_VL;
            end
            PH_W_VL: begin
                seq_remaining = {1'b0, b};
                seq_phase     = PH_W_ACKEND;
            end
            PH_W_ACK_ADDR: begin
                if (!ack) end_op(ST_COMM);
                else if (seq_op == OP_WRITE) open_group(PH_TX_DATA);
                else end_op(ST_OK);
            end
            PH_W_ACKEND: begin
                if (!ack) end_op(ST_COMM);
                else begin
                    if (seq_op == OP_CHIP_ID) seq_id = {seq_xor, seq_remaining[7:0]};
                    if (seq_op == OP_WRITE) begin
                        seq_addr  = seq_addr + 32'(seq_count);
                        seq_count = '0;
                    end
                    end_op(ST_OK);
                end
            end
            default: ;
        endcase
    endfunction

    function automatic void take_start(input logic [2:0] op, input logic restart);
        if (seq_phase != PH_IDLE) return;
        seq_op        = op;
        seq_remaining = '0;
        if (op == OP_CONNECT) begin
            tx_flag   = 1'b1;
            tx_byte   = CMD_CODES[7:0];
            seq_phase = PH_W_CONN;
            return;
        end
        if (!seq_linked) begin
            end_op(ST_NOT_CONN);
            return;
        end
        if (op == OP_WRITE) begin
            if (restart) seq_addr = seq_base;
            if (seq_count == 0) begin
                end_op(ST_OK);
                return;
            end
        end
        open_group(PH_TX_CMD);
    endfunction

    function automatic void take_timeout();
        case (seq_phase)
            PH_W_CONN: begin
                seq_linked = 1'b0;
                end_op(ST_CONN);
            end
            // The final wait of an extended erase may take longer than any timeout.
            PH_W_ACKEND: if (seq_op != OP_EXT_ERASE) end_op(ST_COMM);
            PH_W_ACK1, PH_W_TOTAL, PH_W_VBYTES, PH_W_ONE, PH_W_VH, PH_W_VL,
            PH_W_ACK_ADDR: end_op(ST_COMM);
            default: ;
        endcase
    endfunction

    function automatic result_t host_model_step(input item_t it);
        result_t r;
        tx_flag   = 1'b0;
        tx_byte   = 8'h00;
        done_flag = 1'b0;
        case (it.cmd)
            CMD_START:    take_start(it.operation, it.restart_address);
            CMD_RX:       take_rx(it.rx_value);
            CMD_TIMEOUT:  take_timeout();
            CMD_TX_READY: emit_next();
            CMD_LOAD: begin
                if (seq_phase == PH_IDLE && seq_count < BLOCK_BYTES_DEFAULT) begin
                    seq_buf[seq_count[7:0]] = it.payload_byte;
                    seq_count = seq_count + 9'd1;
                end
            end
            default: ;
        endcase
        if (done_flag) ops_ended++;
        r.tx_valid      = tx_flag;
        r.tx_value      = tx_flag ? tx_byte : 8'h00;
        r.op_done       = done_flag;
        r.status        = seq_status;
        r.busy_res      = (seq_phase != PH_IDLE);
        r.version_major = seq_version[7:4];
        r.version_minor = seq_version[3:0];
        r.device_id     = seq_id;
        r.next_address  = seq_addr;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        error_count++;
        if (error_count <= MAX_PRINTS)
            $display("MISMATCH at result %0d: %s got 0x%0h, expected 0x%0h",
                     results_checked, what, got, want);
    endtask

    task automatic compare_result(input result_t got, input result_t want);
        if (got.tx_valid !== want.tx_valid)
            report_mismatch("tx_valid", got.tx_valid, want.tx_valid);
        if (got.tx_value !== want.tx_value)
            report_mismatch("tx_value", got.tx_value, want.tx_value);
        if (got.op_done !== want.op_done)
            report_mismatch("op_done", got.op_done, want.op_done);
        if (got.status !== want.status)
            report_mismatch("status", got.status, want.status);
        if (got.busy_res !== want.busy_res)
            report_mismatch("busy_res", got.busy_res, want.busy_res);
        if (got.version_major !== want.version_major)
            report_mismatch("version_major", got.version_major, want.version_major);
        if (got.version_minor !== want.version_minor)
            report_mismatch("version_minor", got.version_minor, want.version_minor);
        if (got.device_id !== want.device_id)
            report_mismatch("device_id", got.device_id, want.device_id);
        if (got.next_address !== want.next_address)
            report_mismatch("next_address", got.next_address, want.next_address);
    endtask

    // Result side: each accepted result item is matched against the oldest prediction.
    // The receiver's stall pattern is redrawn every cycle.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            seen = m_tdata[68:0];
            if (due_outputs.size() == 0) begin
                report_mismatch("result item with nothing expected", m_tdata[31:0], 32'h0);
            end else begin
                compare_result(seen, due_outputs.pop_front());
                if (m_tdata[71:69] !== 3'b000)
                    report_mismatch("zero fill", m_tdata[71:69], 32'h0);
            end
            results_checked++;
        end
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    // Sends one item and records its prediction once the block has taken it. The caller
    // either sends again in the same time step or calls release_bus, so s_tvalid never
    // sees two assignments in one step.
    task automatic send_item(input item_t it);
        while ($urandom_range(99) < gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0000, it.restart_address, it.payload_byte, it.rx_value, it.operation};
        s_tuser  <= it.cmd;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        due_outputs.push_back(host_model_step(it));
        items_sent++;
    endtask

    // Lowers valid and waits until every predicted result has been taken.
    task automatic release_bus();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (due_outputs.size() != 0) @(posedge aclk);
        repeat (6) @(posedge aclk);
    endtask

    function automatic item_t make_item(input logic [2:0] c, input logic [2:0] op,
                                        input logic [7:0] rx, input logic [7:0] pay,
                                        input logic rst);
        item_t it;
        it.cmd             = c;
        it.operation       = op;
        it.rx_value        = rx;
        it.payload_byte    = pay;
        it.restart_address = rst;
        return it;
    endfunction

    function automatic item_t random_item();
        item_t it;
        it.cmd             = $urandom_range(7);
        it.operation       = $urandom_range(7);
        it.rx_value        = $urandom_range(255);
        it.payload_byte    = $urandom_range(255);
        it.restart_address = $urandom_range(1);
        return it;
    endfunction

    function automatic bit in_tx_phase();
        return seq_phase == PH_TX_CMD || seq_phase == PH_TX_ERASE || seq_phase == PH_TX_EXT ||
               seq_phase == PH_TX_ADDR || seq_phase == PH_TX_DATA;
    endfunction

    // Mostly small blocks, sometimes an empty one, now and then a longer one.
    function automatic int unsigned pick_fill_goal();
        int unsigned roll;
        roll = $urandom_range(19);
        if (roll < 3) return 0;
        if (roll == 19) return $urandom_range(40, 9);
        return $urandom_range(8, 1);
    endfunction

    // An item that a well-behaved host and target would exchange next, with random
    // content wherever the protocol leaves room; a few replies are still wrong.
    function automatic item_t protocol_item();
        item_t       it;
        int unsigned roll;
        it      = random_item();
        roll    = $urandom_range(99);
        it.cmd  = CMD_RX;
        case (seq_phase)
            PH_IDLE: begin
                if (!seq_linked && roll < 70) begin
                    it.cmd       = CMD_START;
                    it.operation = OP_CONNECT;
                end else if (seq_count < fill_goal) begin
                    it.cmd = CMD_LOAD;
                end else begin
                    it.cmd = CMD_START;
                    if (roll < 30) it.operation = OP_WRITE;
                    it.restart_address = ($urandom_range(3) == 0);
                    if (it.operation == OP_WRITE) fill_goal = pick_fill_goal();
                end
            end
            PH_TX_CMD, PH_TX_ERASE, PH_TX_EXT, PH_TX_ADDR, PH_TX_DATA: it.cmd = CMD_TX_READY;
            PH_W_CONN: begin
                if (roll < 70) it.rx_value = ACK_BYTE;
                else if (roll < 90) it.rx_value = NACK_BYTE;
            end
            PH_W_TOTAL: begin
                if (roll < 90) it.rx_value = $urandom_range(4);
                else it.rx_value = $urandom_range(40);
            end
            PH_W_ONE: if (roll < 95) it.rx_value = ID_PREFIX;
            PH_W_VBYTES, PH_W_VH, PH_W_VL: ;
            default: if (roll < 95) it.rx_value = ACK_BYTE;
        endcase
        return it;
    endfunction

    // Drives the current operation to its end: either cleanly with ACKs, or by aborting
    // with timeouts where the phase allows one.
    task automatic run_to_idle(input bit abort);
        item_t it;
        while (seq_phase != PH_IDLE) begin
            it = random_item();
            if (in_tx_phase()) begin
                it.cmd = CMD_TX_READY;
            end else if (abort && !(seq_phase == PH_W_ACKEND && seq_op == OP_EXT_ERASE)) begin
                it.cmd = CMD_TIMEOUT;
            end else begin
                it.cmd      = CMD_RX;
                it.rx_value = ACK_BYTE;
            end
            send_item(it);
        end
    endtask

    // The register is only written with no operation running and nothing in flight.
    task automatic write_flash_base(input logic [31:0] value);
        run_to_idle(1'b1);
        release_bus();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        seq_base = value;
        cfg_we <= 1'b0;
        @(posedge aclk);
        base_settings++;
    endtask

    task automatic ensure_link();
        if (!seq_linked) begin
            send_item(make_item(CMD_START, OP_CONNECT, 8'h00, 8'h00, 1'b0));
            send_item(make_item(CMD_RX, OP_CONNECT, ACK_BYTE, 8'h00, 1'b0));
        end
    endtask

    // Idle-state noise, commands before connecting, every way a connect can end,
    // an empty write, the timeout that an extended erase ignores and a bad chip id prefix.
    task automatic test_directed();
        gap_pct   = 0;
        stall_pct = 0;
        send_item(make_item(CMD_RX, OP_CONNECT, 8'hFF, 8'h00, 1'b0));
        send_item(make_item(CMD_TIMEOUT, OP_CONNECT, 8'h00, 8'h00, 1'b0));
        send_item(make_item(CMD_TX_READY, OP_CONNECT, 8'h00, 8'h00, 1'b0));
        send_item(make_item(CMD_UNUSED, OP_GO, 8'hFF, 8'hFF, 1'b1));
        send_item(make_item(CMD_START, OP_VERSION, 8'h00, 8'h00, 1'b0));
        send_item(make_item(CMD_START, OP_WRITE, 8'h00, 8'h00, 1'b1));
        send_item(make_item(CMD_START, OP_CONNECT, 8'h00, 8'h00, 1'b0));
        send_item(make_item(CMD_TIMEOUT, OP_CONNECT, 8'h00, 8'h00, 1'b0));
        send_item(make_item(CMD_START, OP_CONNECT, 8'h00, 8'h00, 1'b0));
        send_item(make_item(CMD_RX, OP_CONNECT, 8'h00, 8'h00, 1'b0));
        send_item(make_item(CMD_START, OP_CONNECT, 8'h00, 8'h00, 1'b0));
        send_item(make_item(CMD_RX, OP_CONNECT, NACK_BYTE, 8'h00, 1'b0));
        send_item(make_item(CMD_START, OP_WRITE, 8'h00, 8'h00, 1'b0));
        send_item(make_item(CMD_START, OP_EXT_ERASE, 8'h00, 8'h00, 1'b0));
        send_item(make_item(CMD_TX_READY, OP_CONNECT, 8'h00, 8'h00, 1'b0));
        send_item(make_item(CMD_RX, OP_CONNECT, ACK_BYTE, 8'h00, 1'b0));
        send_item(make_item(CMD_TX_READY, OP_CONNECT, 8'h00, 8'h00, 1'b0));
        send_item(make_item(CMD_TX_READY, OP_CONNECT, 8'h00, 8'h00, 1'b0));
        send_item(make_item(CMD_TIMEOUT, OP_CONNECT, 8'h00, 8'h00, 1'b0));
        send_item(make_item(CMD_RX, OP_CONNECT, ACK_BYTE, 8'h00, 1'b0));
        send_item(make_item(CMD_START, OP_CHIP_ID, 8'h00, 8'h00, 1'b0));
        send_item(make_item(CMD_TX_READY, OP_CONNECT, 8'h00, 8'h00, 1'b0));
        send_item(make_item(CMD_RX, OP_CONNECT, ACK_BYTE, 8'h00, 1'b0));
        send_item(make_item(CMD_RX, OP_CONNECT, 8'h02, 8'h00, 1'b0));
        run_to_idle(1'b1);
    endtask

    // A full 256-byte block (one more load is ignored) written at a base near the top of
    // the address space, so the running address wraps; then a go to the same base.
    task automatic test_full_block();
        int k;
        gap_pct   = 0;
        stall_pct = 0;
        write_flash_base(32'hFFFF_FF80);
        ensure_link();
        for (k = 0; k <= BLOCK_BYTES_DEFAULT; k++) begin
            if (k == 0) send_item(make_item(CMD_LOAD, OP_CONNECT, 8'h00, 8'h00, 1'b0));
            else if (k == 1) send_item(make_item(CMD_LOAD, OP_CONNECT, 8'h00, 8'hFF, 1'b0));
            else send_item(make_item(CMD_LOAD, OP_CONNECT, 8'h00, $urandom_range(255), 1'b0));
        end
        send_item(make_item(CMD_START, OP_WRITE, 8'h00, 8'h00, 1'b1));
        run_to_idle(1'b0);
        send_item(make_item(CMD_START, OP_GO, 8'h00, 8'h00, 1'b0));
        run_to_idle(1'b0);
    endtask

    // Random exchanges, mostly well formed, under one pattern of sender gaps and
    // receiver stalls.
    task automatic test_random(input int count, input int unsigned gap, input int unsigned stall);
        int k;
        gap_pct   = gap;
        stall_pct = stall;
        for (k = 0; k < count; k++) begin
            if ($urandom_range(99) < 88) send_item(protocol_item());
            else send_item(random_item());
        end
        run_to_idle(1'b1);
    endtask

    initial begin
        seq_reset();
        aresetn <= 1'b0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_full_block();

        write_flash_base(32'h0000_0000);
        test_random(25, 0, 0);
        write_flash_base(32'hFFFF_FFFF);
        test_random(25, 88, 0);
        write_flash_base($urandom);
        test_random(25, 0, 88);
        write_flash_base(FLASH_BASE_RESET);
        test_random(25, 28, 28);

        release_bus();
        if (due_outputs.size() != 0)
            report_mismatch("result items never delivered", due_outputs.size(), 32'h0);

        $display("Sent %0d input items and checked %0d result items; %0d operations ended.",
                 items_sent, results_checked, ops_ended);
        $display("Covered %0d flash base settings and a full 256-byte block.",
                 base_settings);
        if (error_count == 0) begin
            $display("uart_bootloader_host_sequencer test passed");
        end else begin
            $display("uart_bootloader_host_sequencer test failed");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #20_000_000;
        $display("Timeout with %0d result items still expected.", due_outputs.size());
        $display("uart_bootloader_host_sequencer test failed");
        $finish;
    end

endmodule
